// File: rtl/crc20_word_stream_defines.svh
// Assertion macros used by the CRC-20 word stream core.
`ifndef CRC20_WORD_STREAM_DEFINES_SVH
`define CRC20_WORD_STREAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRC20_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crc20 same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CRC20_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crc20 next-cycle check failed");

`endif

// File: rtl/crc20_pkg.sv
// Package for the CRC-20 word stream: item type, constants and XOR matrices.
package crc20_pkg;

  localparam int CRC_BITS  = 20;
  localparam int WORD_BITS = 32;

  localparam logic [CRC_BITS-1:0] POLY_A   = 20'hC1ACF;
  localparam logic [CRC_BITS-1:0] POLY_B   = 20'h8359F;
  localparam logic [CRC_BITS-1:0] CRC_SEED = 20'hFFFFF;
  localparam logic [CRC_BITS-1:0] CRC_TOP  = 20'h80000;

  typedef logic [CRC_BITS-1:0][CRC_BITS-1:0]  smat_t;
  typedef logic [WORD_BITS-1:0][CRC_BITS-1:0] dmat_t;

  // One input item with the polynomial choice that goes with it
  typedef struct packed {
    logic [WORD_BITS-1:0] data_word;
    logic                 first_word;
    logic                 last_word;
    logic                 poly_select;
  } crc20_item_t;

  // One forward shift step, message bit entering at bit 0
  function automatic logic [CRC_BITS-1:0] step_f(logic [CRC_BITS-1:0] r, logic b,
                                                 logic [CRC_BITS-1:0] poly);
    logic [CRC_BITS-1:0] n;
    n = {r[CRC_BITS-2:0], b};
    if (r[CRC_BITS-1]) n = n ^ poly;
    return n;
  endfunction

  // Seed run back through 20 reverse steps
  function automatic logic [CRC_BITS-1:0] start_f(logic [CRC_BITS-1:0] poly);
    logic [CRC_BITS-1:0] r;
    r = CRC_SEED;
    for (int k = 0; k < CRC_BITS; k++) begin
      if (r[0]) r = (r >> 1) ^ (CRC_TOP | (poly >> 1));
      else      r = r >> 1;
    end
    return r;
  endfunction

  // Columns of the state-to-result map after one word, optionally augmented
  function automatic smat_t state_cols_f(logic [CRC_BITS-1:0] poly, logic aug);
    smat_t               m;
    logic [CRC_BITS-1:0] r;
    for (int j = 0; j < CRC_BITS; j++) begin
      r    = '0;
      r[j] = 1'b1;
      for (int k = 0; k < WORD_BITS; k++) r = step_f(r, 1'b0, poly);
      if (aug) begin
        for (int k = 0; k < CRC_BITS; k++) r = step_f(r, 1'b0, poly);
      end
      m[j] = r;
    end
    return m;
  endfunction

  // Columns of the word-to-result map, optionally augmented
  function automatic dmat_t data_cols_f(logic [CRC_BITS-1:0] poly, logic aug);
    dmat_t                m;
    logic [CRC_BITS-1:0]  r;
    logic [WORD_BITS-1:0] w;
    for (int j = 0; j < WORD_BITS; j++) begin
      w    = '0;
      w[j] = 1'b1;
      r    = '0;
      for (int k = 0; k < WORD_BITS; k++) r = step_f(r, w[WORD_BITS-1-k], poly);
      if (aug) begin
        for (int k = 0; k < CRC_BITS; k++) r = step_f(r, 1'b0, poly);
      end
      m[j] = r;
    end
    return m;
  endfunction

  // Apply a state map and a word map: XOR of the selected columns
  function automatic logic [CRC_BITS-1:0] apply_f(smat_t s, dmat_t d,
                                                  logic [CRC_BITS-1:0] r,
                                                  logic [WORD_BITS-1:0] w);
    logic [CRC_BITS-1:0] acc;
    acc = '0;
    for (int j = 0; j < CRC_BITS; j++) begin
      if (r[j]) acc = acc ^ s[j];
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      if (w[j]) acc = acc ^ d[j];
    end
    return acc;
  endfunction

  localparam logic [CRC_BITS-1:0] START_A = start_f(POLY_A);
  localparam logic [CRC_BITS-1:0] START_B = start_f(POLY_B);

  localparam smat_t UPD_S_A = state_cols_f(POLY_A, 1'b0);
  localparam smat_t UPD_S_B = state_cols_f(POLY_B, 1'b0);
  localparam dmat_t UPD_D_A = data_cols_f(POLY_A, 1'b0);
  localparam dmat_t UPD_D_B = data_cols_f(POLY_B, 1'b0);
  localparam smat_t AUG_S_A = state_cols_f(POLY_A, 1'b1);
  localparam smat_t AUG_S_B = state_cols_f(POLY_B, 1'b1);
  localparam dmat_t AUG_D_A = data_cols_f(POLY_A, 1'b1);
  localparam dmat_t AUG_D_B = data_cols_f(POLY_B, 1'b1);

endpackage

// File: rtl/crc20_in_reg.sv
// Input register stage of the CRC-20 word stream.
module crc20_in_reg
  import crc20_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_BITS-1:0] data_word_i,
  input  logic                 first_word_i,
  input  logic                 last_word_i,
  input  logic                 poly_select_i,
  input  logic                 take_i,
  output logic                 item_valid_o,
  output crc20_item_t          item_o
);

  logic        valid_q, valid_d;
  crc20_item_t item_q;
  logic        load;

  // Stall only while a held item cannot move on
  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~take_i);

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the item with the polynomial in force
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{data_word:   data_word_i,
                  first_word:  first_word_i,
                  last_word:   last_word_i,
                  poly_select: poly_select_i};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: rtl/crc20_core.sv
// CRC state, unrolled word update and result register of the CRC-20 word stream.
`include "crc20_word_stream_defines.svh"
module crc20_core
  import crc20_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  crc20_item_t         item_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CRC_BITS-1:0] crc_value_o
);

  logic [CRC_BITS-1:0] crc_q, crc_d;
  logic [CRC_BITS-1:0] res_q;
  logic                out_valid_q, out_valid_d;
  logic [CRC_BITS-1:0] base;
  logic [CRC_BITS-1:0] aug;
  logic                out_free;
  logic                take;
  logic                take_last;

  // Move an item when it has no result or the result slot frees up
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign take      = item_valid_i & (~item_i.last_word | out_free);
  assign take_last = take & item_i.last_word;
  assign take_o    = take;

  // Pick the starting point: fresh seed on a first word
  always_comb begin
    if (item_i.first_word) base = item_i.poly_select ? START_B : START_A;
    else                   base = crc_q;
  end

  // Advance the register by one word, and form the augmented copy
  always_comb begin
    if (item_i.poly_select) begin
      crc_d = apply_f(UPD_S_B, UPD_D_B, base, item_i.data_word);
      aug   = apply_f(AUG_S_B, AUG_D_B, base, item_i.data_word);
    end else begin
      crc_d = apply_f(UPD_S_A, UPD_D_A, base, item_i.data_word);
      aug   = apply_f(AUG_S_A, AUG_D_A, base, item_i.data_word);
    end
  end

  // Fill the result slot on a last word, drop it once taken
  always_comb begin
    if (take_last)                      out_valid_d = 1'b1;
    else if (out_valid_q & ~out_stall_i) out_valid_d = 1'b0;
    else                                out_valid_d = out_valid_q;
  end

  // Hold CRC state and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= START_A;
      out_valid_q <= 1'b0;
    end else begin
      if (take) crc_q <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result value
  always_ff @(posedge clk_i) begin
    if (take_last) res_q <= aug;
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = res_q;

  `CRC20_ASSERT_NEXT(a_last_fills_slot, take_last, out_valid_q)
  `CRC20_ASSERT_NOW(a_full_slot_blocks_last,
                    item_valid_i && item_i.last_word && out_valid_q && out_stall_i, !take)
  `CRC20_ASSERT_NEXT(a_crc_holds_when_idle, !take, crc_q == $past(crc_q))
  `CRC20_ASSERT_NOW(a_result_from_last, $rose(out_valid_q), $past(take_last))

endmodule

// File: rtl/crc20_word_stream.sv
// Top level of the CRC-20 word stream: config register and stage wiring.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    data_word_i, first_word_i, last_word_i
//   out      output     out_valid_o / out_stall_i  crc_value_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_data_i (poly_select)
//
// One word per cycle while no stall holds it; a CRC leaves from the result register.
// Each word passes an input register, then a 32-bit unrolled XOR update
// (augmentation folded in) that loads the CRC register and, on a last word, the result register.
// Reset clears valids, selects polynomial 0xC1ACF and loads its start value.
// A stalled result blocks only a following last word; other words flow on.
module crc20_word_stream
  import crc20_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_BITS-1:0] data_word_i,
  input  logic                 first_word_i,
  input  logic                 last_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CRC_BITS-1:0]  crc_value_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i
);

  logic        poly_q;
  logic        item_valid;
  crc20_item_t item;
  logic        take;

  assign cfg_ready_o = 1'b1;

  // Hold the polynomial select register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      poly_q <= cfg_data_i;
    end
  end

  crc20_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_word_i   (data_word_i),
    .first_word_i  (first_word_i),
    .last_word_i   (last_word_i),
    .poly_select_i (poly_q),
    .take_i        (take),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  crc20_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .crc_value_o  (crc_value_o)
  );

endmodule
